// ===== design/base64_y64_encoder_macros.svh =====
// Assertion helpers for the encoder checker.
`ifndef BASE64_Y64_ENCODER_MACROS_SVH
`define BASE64_Y64_ENCODER_MACROS_SVH

// Property checked only outside reset.
`define B64Y_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked at every edge, reset included.
`define B64Y_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== design/b64y_pkg.sv =====
// ---------------------------------------------------------------------------
// b64y_pkg
// Shared types, constants and the symbol mapping of the base64 encoder.
// ---------------------------------------------------------------------------
package b64y_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_SYM62 = 2'd0;
   localparam logic [1:0] CSR_SYM63 = 2'd1;
   localparam logic [1:0] CSR_PAD   = 2'd2;

   // Configuration reset values
   localparam logic [7:0] SYM62_RESET = 8'd46;  // '.'
   localparam logic [7:0] SYM63_RESET = 8'd95;  // '_'
   localparam logic [7:0] PAD_RESET   = 8'd45;  // '-'

   // Default depth of the job queue between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Alphabet ranges
   localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
   localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
   localparam logic [7:0] CHAR_DIGIT_0  = 8'h30;
   localparam logic [7:0] SYM_LOWER_BASE = 8'd26;
   localparam logic [7:0] SYM_DIGIT_BASE = 8'd52;
   localparam logic [5:0] SYM_VALUE_62  = 6'd62;
   localparam logic [5:0] SYM_VALUE_63  = 6'd63;

   // Configuration as seen by the back end
   typedef struct packed {
      logic [7:0] sym62;
      logic [7:0] sym63;
      logic [7:0] pad;
   } cfg_type;

   // One classified request: up to four characters to emit
   typedef struct packed {
      logic [3:0][5:0] code;      // six-bit symbol per slot
      logic [3:0]      pad;       // slot is a pad character
      logic [1:0]      last_idx;  // index of the final slot used
      logic            msg_end;   // final slot closes the message
   } job_type;

   // Six-bit value to ASCII
   function automatic logic [7:0] map_symbol(logic [5:0] code, logic [7:0] sym62,
                                             logic [7:0] sym63);
      logic [7:0] c;
      c = {2'b00, code};
      priority if (c < SYM_LOWER_BASE) begin
         return CHAR_UPPER_A + c;
      end else if (c < SYM_DIGIT_BASE) begin
         return c + (CHAR_LOWER_A - SYM_LOWER_BASE);
      end else if (code == SYM_VALUE_62) begin
         return sym62;
      end else if (code == SYM_VALUE_63) begin
         return sym63;
      end else begin
         return c - (SYM_DIGIT_BASE - CHAR_DIGIT_0);
      end
   endfunction

endpackage

// ===== design/b64y_front.sv =====
// ---------------------------------------------------------------------------
// b64y_front
// Takes raw bytes, tracks the position in the 3-byte group and turns each
// request into one job of symbol codes and pad slots.
// ---------------------------------------------------------------------------
module b64y_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] in_byte
   input  logic              req_tlast,   // last_byte
   output logic              push_valid,
   input  logic              push_ready,
   output b64y_pkg::job_type push_data
);
   import b64y_pkg::*;

   typedef enum logic [1:0] {
      PHASE_START  = 2'd0,
      PHASE_SECOND = 2'd1,
      PHASE_THIRD  = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] left_ff, left_in;
   logic       accept;
   job_type    job;

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign accept     = req_tvalid && push_ready;
   assign push_data  = job;

   // Classify the byte by group position
   always_comb begin
      job          = '0;
      phase_in     = PHASE_START;
      left_in      = '0;
      job.msg_end  = req_tlast;
      unique case (phase_ff)
         PHASE_SECOND: begin
            job.code[0] = {left_ff[1:0], req_tdata[7:4]};
            if (req_tlast) begin
               job.code[1]  = {req_tdata[3:0], 2'b00};
               job.pad[2]   = 1'b1;
               job.last_idx = 2'd2;
            end else begin
               left_in  = req_tdata[3:0];
               phase_in = PHASE_THIRD;
            end
         end
         PHASE_THIRD: begin
            job.code[0]  = {left_ff, req_tdata[7:6]};
            job.code[1]  = req_tdata[5:0];
            job.last_idx = 2'd1;
         end
         default: begin
            // group start; the unused phase code behaves the same
            job.code[0] = req_tdata[7:2];
            if (req_tlast) begin
               job.code[1]  = {req_tdata[1:0], 4'b0000};
               job.pad[2]   = 1'b1;
               job.pad[3]   = 1'b1;
               job.last_idx = 2'd3;
            end else begin
               left_in  = {2'b00, req_tdata[1:0]};
               phase_in = PHASE_SECOND;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_START;
         left_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

endmodule

// ===== design/b64y_queue.sv =====
// ---------------------------------------------------------------------------
// b64y_queue
// Small flop-based FIFO of jobs between the front and back ends.
// ---------------------------------------------------------------------------
module b64y_queue #(
   parameter int DEPTH = b64y_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  b64y_pkg::job_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output b64y_pkg::job_type pop_data
);
   import b64y_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== design/b64y_back.sv =====
// ---------------------------------------------------------------------------
// b64y_back
// Walks the slots of the head job, one character per cycle unless stalled,
// maps codes to ASCII and drives the registered response channel.
// ---------------------------------------------------------------------------
module b64y_back (
   input  logic              clock,
   input  logic              reset,
   input  b64y_pkg::cfg_type cfg,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  b64y_pkg::job_type pop_data,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // [7:0] out_char
   output logic              rsp_tlast    // last_char
);
   import b64y_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       load, take, final_slot;

   assign load       = !valid_ff || rsp_tready;
   assign take       = load && pop_valid;
   assign final_slot = (idx_ff == pop_data.last_idx);
   assign pop_ready  = take && final_slot;

   // Next character and slot
   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (take) begin
         valid_in = 1'b1;
         idx_in   = final_slot ? 2'd0 : idx_ff + 2'd1;
         char_in  = pop_data.pad[idx_ff] ? cfg.pad
                  : map_symbol(pop_data.code[idx_ff], cfg.sym62, cfg.sym63);
         last_in  = pop_data.msg_end && final_slot;
      end else if (load) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== design/base64_y64_encoder.sv =====
// ---------------------------------------------------------------------------
// base64_y64_encoder
// Streaming base64 encoder with configurable symbols 62, 63 and pad.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one raw byte per request, tlast on the final byte of a message.
//   rsp_*  : one ASCII character per transfer, tlast on the final character.
//   csr_*  : write port; index 0 symbol 62, 1 symbol 63, 2 pad character.
//            Write only while the encoder is idle.
// Path: an accepted request's job is written into the job queue, and its
//   first character is then loaded into the output register.
// Throughput: the back end emits one character per cycle while rsp_tready
//   is high, and a byte yields one to four characters (four per three bytes
//   over full groups); the output rate sets the pace. The job queue
//   (QUEUE_DEPTH entries) lets requests arrive while characters drain.
// Reset: synchronous; clears group position, queue and output valid, and
//   restores '.', '_' and '-' as the configurable characters.
// Stall: while rsp_tready is low the output character holds; once the queue
//   fills, req_tready drops until the back end frees an entry.
// ---------------------------------------------------------------------------
module base64_y64_encoder #(
   parameter int QUEUE_DEPTH = b64y_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] in_byte
   input  logic       req_tlast,    // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] out_char
   output logic       rsp_tlast,    // last_char
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import b64y_pkg::*;

   cfg_type cfg_ff;
   logic    push_valid, push_ready, pop_valid, pop_ready;
   job_type push_data, pop_data;

   // Configuration registers; index past the last register is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sym62 <= SYM62_RESET;
         cfg_ff.sym63 <= SYM63_RESET;
         cfg_ff.pad   <= PAD_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_SYM62) cfg_ff.sym62 <= csr_wdata;
         if (csr_index == CSR_SYM63) cfg_ff.sym63 <= csr_wdata;
         if (csr_index == CSR_PAD)   cfg_ff.pad   <= csr_wdata;
      end
   end

   b64y_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   b64y_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   b64y_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== design/b64y_checker.sv =====
// ---------------------------------------------------------------------------
// b64y_checker
// Port-level checks of the encoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "base64_y64_encoder_macros.svh"

module b64y_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // A stalled character holds its value and flag
   `B64Y_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "response changed while stalled")

   // Reset leaves nothing to deliver
   `B64Y_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "response valid right after reset")

   // Reset leaves the queue empty, so requests are taken at once
   `B64Y_ASSERT_ALWAYS(a_reset_ready, reset |=> req_tready, "request side not ready after reset")

endmodule

bind base64_y64_encoder b64y_checker u_checker (.*);

// ===== dv/base64_y64_encoder_tb.sv =====
// ---------------------------------------------------------------------------
// base64_y64_encoder_tb
// Self-checking bench for the streaming base64 encoder. Raw bytes go in as
// requests and the expected characters are predicted per accepted request.
// Each character that leaves the encoder is compared with the oldest
// prediction. Directed messages cover every group ending and both
// configurable symbols. Random messages then run under several register
// settings, with random gaps on the request side and stalls on the
// response side.
// ---------------------------------------------------------------------------
module base64_y64_encoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import b64y_pkg::*;

   localparam logic [1:0] CSR_UNUSED     = 2'd3;  // no register here, writes ignored
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         BYTES_PER_PHASE = 22;

   // One encoded character as it leaves the encoder
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } enc_char_type;

   // Predicts the encoded text and checks the characters as they arrive
   class char_scoreboard;
      logic [7:0] sym62;
      logic [7:0] sym63;
      logic [7:0] pad;
      logic [1:0] phase;      // bytes already taken of the current group
      logic [3:0] leftover;   // low bits of the previous byte, not yet emitted
      enc_char_type expected_chars[$];
      int         errors;

      function new();
         sym62    = SYM62_RESET;
         sym63    = SYM63_RESET;
         pad      = PAD_RESET;
         phase    = 2'd0;
         leftover = 4'd0;
         errors   = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [7:0] value);
         case (idx)
            CSR_SYM62: sym62 = value;
            CSR_SYM63: sym63 = value;
            CSR_PAD:   pad   = value;
            default: ;
         endcase
      endfunction

      // Six-bit value to its ASCII character
      function logic [7:0] symbol_char(logic [5:0] v);
         logic [7:0] c;
         c = {2'b00, v};
         if (v == SYM_VALUE_62) return sym62;
         if (v == SYM_VALUE_63) return sym63;
         if (c < 8'd26) return 8'h41 + c;
         if (c < 8'd52) return 8'h61 + (c - 8'd26);
         return 8'h30 + (c - 8'd52);
      endfunction

      function void push_char(logic [7:0] ch, logic last);
         enc_char_type e;
         e.ch   = ch;
         e.last = last;
         expected_chars.push_back(e);
      endfunction

      // Accepted byte: predict the characters it completes
      function void encode_byte(logic [7:0] b, logic last);
         case (phase)
            2'd1: begin
               push_char(symbol_char({leftover[1:0], b[7:4]}), 1'b0);
               if (last) begin
                  push_char(symbol_char({b[3:0], 2'b00}), 1'b0);
                  push_char(pad, 1'b1);
                  phase    = 2'd0;
                  leftover = 4'd0;
               end else begin
                  leftover = b[3:0];
                  phase    = 2'd2;
               end
            end
            2'd2: begin
               push_char(symbol_char({leftover, b[7:6]}), 1'b0);
               push_char(symbol_char(b[5:0]), last);
               phase    = 2'd0;
               leftover = 4'd0;
            end
            default: begin
               push_char(symbol_char(b[7:2]), 1'b0);
               if (last) begin
                  push_char(symbol_char({b[1:0], 4'b0000}), 1'b0);
                  push_char(pad, 1'b0);
                  push_char(pad, 1'b1);
                  phase    = 2'd0;
                  leftover = 4'd0;
               end else begin
                  leftover = {2'b00, b[1:0]};
                  phase    = 2'd1;
               end
            end
         endcase
      endfunction

      function void check_char(logic [7:0] ch, logic last);
         enc_char_type want;
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected character: expected none, actual %h last %b",
                     $time, ch, last);
            errors++;
            return;
         end
         want = expected_chars.pop_front();
         if (want.ch !== ch) begin
            $display("%0t: out_char mismatch: expected %h, actual %h", $time, want.ch, ch);
            errors++;
         end
         if (want.last !== last) begin
            $display("%0t: last_char mismatch: expected %b, actual %b",
                     $time, want.last, last);
            errors++;
         end
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;    // [7:0] in_byte
   logic       req_tlast;    // last_byte
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;    // [7:0] out_char
   logic       rsp_tlast;    // last_char
   logic       csr_we;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;

   char_scoreboard sb = new();
   bit             no_gaps;
   int             stall_left = 0;
   int             idle_cycles = 0;

   base64_y64_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Response side back-pressure
   always @(negedge clock) begin
      if (reset || no_gaps) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         stall_left = pick_gap();
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Character monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_char(rsp_tdata, rsp_tlast);
   end

   // Watchdog: too long without any transfer ends the run
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d characters outstanding",
                  $time, sb.pending());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // All driver tasks start and end at a falling edge.
   task automatic send_byte(logic [7:0] b, logic last);
      int gap;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.encode_byte(b, last);
      @(negedge clock);
   endtask

   task automatic send_message(int len);
      int         r;
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 9);
         b = (r == 0) ? 8'hFF : (r == 1) ? 8'h00 : 8'($urandom);
         send_byte(b, i == len - 1);
      end
   endtask

   // Hold off requests until every predicted character has come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Leaves csr_we high; program_regs lowers it after the last write
   task automatic write_reg(logic [1:0] idx, logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
      @(negedge clock);
   endtask

   task automatic program_regs(logic [7:0] s62, logic [7:0] s63, logic [7:0] p);
      write_reg(CSR_SYM62, s62);
      write_reg(CSR_SYM63, s63);
      write_reg(CSR_PAD, p);
      if ($urandom_range(0, 1)) write_reg(CSR_UNUSED, 8'($urandom));
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      int sent;
      int len;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      csr_we     = 1'b0;
      csr_index  = 2'd0;
      csr_wdata  = 8'h00;
      no_gaps    = 1'b0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: one byte (two pads), extremes, symbol 63
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      // Two bytes, one pad, symbol 62
      send_byte(8'hFB, 1'b0);
      send_byte(8'hEF, 1'b1);
      // Full groups, no pad
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h10, 1'b0);
      send_byte(8'h83, 1'b1);
      // Message ends one byte into the second group
      send_byte(8'h4D, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h6E, 1'b0);
      send_byte(8'h21, 1'b1);
      // Sender pauses mid-message until the encoder has drained
      send_byte(8'hF0, 1'b0);
      send_byte(8'h0F, 1'b0);
      send_byte(8'hAA, 1'b0);
      wait_drained();
      send_byte(8'h55, 1'b0);
      send_byte(8'hC3, 1'b1);
      // Register extremes, with the write to the unused index
      wait_drained();
      program_regs(8'h00, 8'h00, 8'h00);
      write_reg(CSR_UNUSED, 8'hFF);
      csr_we <= 1'b0;
      @(negedge clock);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFB, 1'b1);
      wait_drained();
      program_regs(8'hFF, 8'hFF, 8'hFF);
      send_byte(8'hFB, 1'b1);

      // Random messages under several register settings
      for (int ph = 0; ph < 4; ph++) begin
         wait_drained();
         case (ph)
            0: program_regs(8'($urandom), 8'($urandom), 8'($urandom));
            1: program_regs(8'h00, 8'h00, 8'h00);
            2: program_regs(8'hFF, 8'hFF, 8'hFF);
            default: program_regs(SYM62_RESET, SYM63_RESET, PAD_RESET);
         endcase
         no_gaps = (ph == 2);
         sent = 0;
         while (sent < BYTES_PER_PHASE) begin
            len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 20);
            send_message(len);
            sent += len;
         end
      end
      no_gaps = 1'b0;

      wait_drained();
      repeat (20) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== base64_y64_encoder.f =====
+incdir+design
design/b64y_pkg.sv
design/b64y_front.sv
design/b64y_queue.sv
design/b64y_back.sv
design/base64_y64_encoder.sv
design/b64y_checker.sv
dv/base64_y64_encoder_tb.sv
